// ----- sv/ptpi_pkg.sv -----
// ----------------------------------------------------------------------------
// ptpi_pkg: shared types and constants of the planar twist pose integrator
// Word types, Q30 trig constants, the CORDIC arctangent table and helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptpi_pkg;

	localparam int THR_W  = 16;
	localparam int DISP_W = 34;

	typedef logic signed [31:0] word_t;
	typedef logic signed [63:0] num_t;
	typedef logic signed [DISP_W-1:0] disp_t;
	typedef logic [THR_W-1:0] thresh_t;

	// Q30 angle and trig constants, and the displacement limit
	localparam logic [33:0]        TWO_PI_U    = 34'd6746518852;
	localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
	localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
	localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
	localparam logic [DISP_W-1:0]  DISP_LIMIT  = 34'd4294967296;

	// input word
	typedef struct packed {
		word_t pose_angle;
		word_t pose_x;
		word_t pose_y;
		word_t rate_angular;
		word_t rate_forward;
		word_t rate_lateral;
	} item_t;

	// result word
	typedef struct packed {
		word_t new_angle;
		word_t new_x;
		word_t new_y;
	} result_t;

	// arctangent of 2^-k in Q30
	function automatic logic signed [33:0] atan_q30(input logic [4:0] k);
		case (k)
			5'd0:  return 34'sd843314856;
			5'd1:  return 34'sd497837829;
			5'd2:  return 34'sd263043836;
			5'd3:  return 34'sd133525158;
			5'd4:  return 34'sd67021686;
			5'd5:  return 34'sd33543515;
			5'd6:  return 34'sd16775850;
			5'd7:  return 34'sd8388437;
			5'd8:  return 34'sd4194282;
			5'd9:  return 34'sd2097149;
			5'd10: return 34'sd1048575;
			5'd11: return 34'sd524287;
			5'd12: return 34'sd262143;
			5'd13: return 34'sd131071;
			5'd14: return 34'sd65535;
			5'd15: return 34'sd32767;
			5'd16: return 34'sd16383;
			5'd17: return 34'sd8191;
			5'd18: return 34'sd4095;
			5'd19: return 34'sd2047;
			5'd20: return 34'sd1023;
			5'd21: return 34'sd511;
			5'd22: return 34'sd255;
			5'd23: return 34'sd127;
			5'd24: return 34'sd63;
			5'd25: return 34'sd31;
			5'd26: return 34'sd15;
			5'd27: return 34'sd8;
			5'd28: return 34'sd4;
			5'd29: return 34'sd2;
			5'd30: return 34'sd1;
			default: return 34'sd0;
		endcase
	endfunction

	// magnitude at or below the threshold
	function automatic logic near_zero(input logic signed [35:0] v, input thresh_t th);
		logic [35:0] m;
		m = v[35] ? (36'd0 - 36'(v)) : 36'(v);
		return m <= 36'(th);
	endfunction

	// clamp to the 32-bit signed range
	function automatic word_t sat_word(input logic signed [37:0] v);
		word_t r;
		if (v > 38'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -38'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- sv/planar_twist_pose_integrator.sv -----
// ----------------------------------------------------------------------------
// planar_twist_pose_integrator: SE(2) twist integration of a planar pose
// Integrates a body twist held for one unit step onto a pose, Q(FRAC_BITS).
// ----------------------------------------------------------------------------
// Usage
//   Input word: item (pose and twist). It is taken at each rising edge with
//   start high and busy low; busy is always low, so one word a cycle enters.
//   Result word: result, on the ports for one cycle with done high. The
//   receiver cannot stall and the pipeline never holds; each input gives
//   exactly one result, in order.
//   Pipeline: done follows the range reduction (5), the CORDIC chain
//   (CORDIC_STAGES + 1), numerator products and sums (2), the 34-bit
//   restoring divider (36) and the heading rotation, saturation and snap
//   (3), all registered.
//   Throughput: one word per clock.
//   Config: cfg_we writes cfg_wdata into the zero threshold; write it only
//   while the pipeline is empty.
//   Reset: arst_n clears all valid bits and sets the threshold to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module planar_twist_pose_integrator #(
	parameter int FRAC_BITS     = 16,
	parameter int CORDIC_STAGES = 18
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ptpi_pkg::item_t     item,
	input  logic                cfg_we,
	input  ptpi_pkg::thresh_t   cfg_wdata,
	output logic                done,
	output ptpi_pkg::result_t   result
);
	import ptpi_pkg::*;

	typedef struct packed {
		logic  turn;
		item_t item;
	} side_a_t;

	typedef struct packed {
		logic  turn;
		item_t item;
		word_t hc;
		word_t hs;
	} side_b_t;

	localparam int SIDE_A_W = $bits(side_a_t);
	localparam int SIDE_B_W = $bits(side_b_t);

	// threshold register
	thresh_t thresh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= '0;
		end else if (cfg_we) begin
			thresh_q <= cfg_wdata;
		end
	end

	assign busy = 1'b0;

	// sine and cosine of the twist rate (lane 0) and heading (lane 1)
	side_a_t             side_in;
	word_t               ang_in [2];
	logic                sc_valid;
	word_t               sc_cos [2];
	word_t               sc_sin [2];
	logic [SIDE_A_W-1:0] sc_side_bits;
	side_a_t             sc_side;

	assign side_in.turn = !near_zero(36'(item.rate_angular), thresh_q);
	assign side_in.item = item;
	assign ang_in[0]    = item.rate_angular;
	assign ang_in[1]    = item.pose_angle;
	assign sc_side      = side_a_t'(sc_side_bits);

	ptpi_sincos #(
		.FRAC_BITS     (FRAC_BITS),
		.CORDIC_STAGES (CORDIC_STAGES),
		.SIDE_W        (SIDE_A_W)
	) u_sincos (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.in_angle  (ang_in),
		.in_side   (side_in),
		.out_valid (sc_valid),
		.out_cos   (sc_cos),
		.out_sin   (sc_sin),
		.out_side  (sc_side_bits)
	);

	// s1: numerator products
	logic    vld_s1;
	side_b_t side_s1;
	num_t    prod_s1 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= sc_valid;
		end
	end

	always_ff @(posedge clk) begin
		side_s1.turn <= sc_side.turn;
		side_s1.item <= sc_side.item;
		side_s1.hc   <= sc_cos[1];
		side_s1.hs   <= sc_sin[1];
		prod_s1[0]   <= 64'(sc_side.item.rate_forward) * 64'(sc_sin[0]);
		prod_s1[1]   <= 64'(sc_side.item.rate_lateral) * (64'(sc_cos[0]) - 64'(ONE_Q30));
		prod_s1[2]   <= 64'(sc_side.item.rate_forward) * (64'(ONE_Q30) - 64'(sc_cos[0]));
		prod_s1[3]   <= 64'(sc_side.item.rate_lateral) * 64'(sc_sin[0]);
	end

	// s2: numerator sums
	logic    vld_s2;
	side_b_t side_s2;
	num_t    num_s2 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s2   <= side_s1;
		num_s2[0] <= prod_s1[0] + prod_s1[1];
		num_s2[1] <= prod_s1[2] + prod_s1[3];
	end

	// arc displacement divide
	logic                dv_valid;
	disp_t               dv_quo [2];
	logic [SIDE_B_W-1:0] dv_side_bits;
	side_b_t             dv_side;

	assign dv_side = side_b_t'(dv_side_bits);

	ptpi_arc_divide #(
		.FRAC_BITS (FRAC_BITS),
		.SIDE_W    (SIDE_B_W)
	) u_divide (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.in_num    (num_s2),
		.in_rate   (side_s2.item.rate_angular),
		.in_side   (side_s2),
		.out_valid (dv_valid),
		.out_quo   (dv_quo),
		.out_side  (dv_side_bits)
	);

	// s3: choose arc or straight displacement, rotate by the heading
	disp_t              dsel_x;
	disp_t              dsel_y;
	logic               vld_s3;
	side_b_t            side_s3;
	logic signed [65:0] rot_s3 [4];

	always_comb begin
		dsel_x = dv_side.turn ? dv_quo[0] : DISP_W'(dv_side.item.rate_forward);
		dsel_y = dv_side.turn ? dv_quo[1] : DISP_W'(dv_side.item.rate_lateral);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		side_s3   <= dv_side;
		rot_s3[0] <= 66'(dv_side.hc) * 66'(dsel_x);
		rot_s3[1] <= 66'(dv_side.hs) * 66'(dsel_y);
		rot_s3[2] <= 66'(dv_side.hs) * 66'(dsel_x);
		rot_s3[3] <= 66'(dv_side.hc) * 66'(dsel_y);
	end

	// s4: position and heading sums and saturation
	logic signed [37:0] term [4];
	logic signed [37:0] sum_x;
	logic signed [37:0] sum_y;
	logic signed [37:0] sum_a;
	logic               vld_s4;
	word_t              ang_s4;
	word_t              x_s4;
	word_t              y_s4;

	always_comb begin
		for (int t = 0; t < 4; t++) begin
			term[t] = 38'(rot_s3[t] >>> 30);
		end
		sum_x = 38'(side_s3.item.pose_x) + term[0] - term[1];
		sum_y = 38'(side_s3.item.pose_y) + term[2] + term[3];
		sum_a = 38'(side_s3.item.pose_angle)
			+ (side_s3.turn ? 38'(side_s3.item.rate_angular) : 38'sd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		ang_s4 <= sat_word(sum_a);
		x_s4   <= sat_word(sum_x);
		y_s4   <= sat_word(sum_y);
	end

	// s5: snap small values to zero, output register
	logic    done_s5;
	result_t result_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s5 <= 1'b0;
		end else begin
			done_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		result_s5.new_angle <= near_zero(36'(ang_s4), thresh_q) ? '0 : ang_s4;
		result_s5.new_x     <= near_zero(36'(x_s4), thresh_q) ? '0 : x_s4;
		result_s5.new_y     <= near_zero(36'(y_s4), thresh_q) ? '0 : y_s4;
	end

	assign done   = done_s5;
	assign result = result_s5;

	// checks
	a_snap_pos: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((result.new_x == 0 || !near_zero(36'(result.new_x), thresh_q)) &&
			(result.new_y == 0 || !near_zero(36'(result.new_y), thresh_q))))
		else $error("position word not snapped");

	a_snap_ang: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.new_angle == 0 || !near_zero(36'(result.new_angle), thresh_q)))
		else $error("heading word not snapped");

	a_tail_valid: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_s3, 2))
		else $error("result word without a source in the rotation stage");

endmodule

`default_nettype wire

// ----- sv/ptpi_sincos.sv -----
// ----------------------------------------------------------------------------
// ptpi_sincos: two-lane pipelined sine and cosine
// Range reduction to [-pi/2, pi/2] in five stages, then one CORDIC rotation
// per stage, then the quadrant flip. Q(FRAC_BITS) in, Q30 out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptpi_sincos #(
	parameter int FRAC_BITS     = 16,
	parameter int CORDIC_STAGES = 18,
	parameter int SIDE_W        = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  ptpi_pkg::word_t     in_angle [2],
	input  logic [SIDE_W-1:0]   in_side,
	output logic                out_valid,
	output ptpi_pkg::word_t     out_cos [2],
	output ptpi_pkg::word_t     out_sin [2],
	output logic [SIDE_W-1:0]   out_side
);
	import ptpi_pkg::*;

	localparam int S      = 30 - FRAC_BITS;
	localparam int P      = 41;
	localparam int RECIP_W = S + 9;
	localparam int QW     = S + 1;
	localparam int PROD_W = RECIP_W + 33;
	localparam int DW2    = S + 35;
	localparam int CW     = 34;
	localparam logic [127:0] RECIP_FULL = (128'd1 << (S + P)) / 128'd6746518852;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

	// stage 1: magnitude and quotient estimate
	logic [31:0]         mag [2];
	logic [PROD_W-1:0]   prod [2];
	logic                vld_s1;
	logic [SIDE_W-1:0]   side_s1;
	logic [31:0]         mag_s1 [2];
	logic [QW-1:0]       q_s1 [2];
	logic                neg_s1 [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			mag[l]  = in_angle[l][31] ? (32'd0 - 32'(in_angle[l])) : 32'(in_angle[l]);
			prod[l] = PROD_W'(mag[l]) * PROD_W'(RECIP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= in_side;
		for (int l = 0; l < 2; l++) begin
			mag_s1[l] <= mag[l];
			q_s1[l]   <= prod[l][P +: QW];
			neg_s1[l] <= in_angle[l][31];
		end
	end

	// stage 2: remainder below twice the period
	logic [DW2-1:0]      rem_full [2];
	logic                vld_s2;
	logic [SIDE_W-1:0]   side_s2;
	logic [34:0]         rem_s2 [2];
	logic                neg_s2 [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			rem_full[l] = (DW2'(mag_s1[l]) << S) - DW2'(q_s1[l]) * DW2'(TWO_PI_U);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s2 <= side_s1;
		for (int l = 0; l < 2; l++) begin
			rem_s2[l] <= rem_full[l][34:0];
			neg_s2[l] <= neg_s1[l];
		end
	end

	// stage 3: final correction and sign of the dividend
	logic [34:0]              remc [2];
	logic signed [35:0]       rpos [2];
	logic                     vld_s3;
	logic [SIDE_W-1:0]        side_s3;
	logic signed [35:0]       r_s3 [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			remc[l] = (rem_s2[l] >= 35'(TWO_PI_U)) ? rem_s2[l] - 35'(TWO_PI_U) : rem_s2[l];
			rpos[l] = $signed({1'b0, remc[l]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		side_s3 <= side_s2;
		for (int l = 0; l < 2; l++) begin
			r_s3[l] <= neg_s2[l] ? -rpos[l] : rpos[l];
		end
	end

	// stage 4: fold into [-pi, pi]
	logic                vld_s4;
	logic [SIDE_W-1:0]   side_s4;
	logic signed [35:0]  r_s4 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		side_s4 <= side_s3;
		for (int l = 0; l < 2; l++) begin
			if (r_s3[l] > PI_Q30) begin
				r_s4[l] <= r_s3[l] - TWO_PI_Q30;
			end else if (r_s3[l] < -PI_Q30) begin
				r_s4[l] <= r_s3[l] + TWO_PI_Q30;
			end else begin
				r_s4[l] <= r_s3[l];
			end
		end
	end

	// stage 5: fold into [-pi/2, pi/2], seed the rotator
	logic                vld_c [CORDIC_STAGES+1];
	logic [SIDE_W-1:0]   side_c [CORDIC_STAGES+1];
	logic                flip_c [CORDIC_STAGES+1][2];
	logic signed [CW-1:0] x_c [CORDIC_STAGES+1][2];
	logic signed [CW-1:0] y_c [CORDIC_STAGES+1][2];
	logic signed [CW-1:0] z_c [CORDIC_STAGES+1][2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c[0] <= 1'b0;
		end else begin
			vld_c[0] <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		side_c[0] <= side_s4;
		for (int l = 0; l < 2; l++) begin
			x_c[0][l] <= GAIN_Q30;
			y_c[0][l] <= '0;
			if (r_s4[l] > HALF_PI_Q30) begin
				z_c[0][l]    <= CW'(r_s4[l] - PI_Q30);
				flip_c[0][l] <= 1'b1;
			end else if (r_s4[l] < -HALF_PI_Q30) begin
				z_c[0][l]    <= CW'(r_s4[l] + PI_Q30);
				flip_c[0][l] <= 1'b1;
			end else begin
				z_c[0][l]    <= CW'(r_s4[l]);
				flip_c[0][l] <= 1'b0;
			end
		end
	end

	// rotation stages
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
		localparam int K = i % 32;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_c[i+1] <= 1'b0;
			end else begin
				vld_c[i+1] <= vld_c[i];
			end
		end

		always_ff @(posedge clk) begin
			side_c[i+1] <= side_c[i];
			for (int l = 0; l < 2; l++) begin
				flip_c[i+1][l] <= flip_c[i][l];
				if (!z_c[i][l][CW-1]) begin
					x_c[i+1][l] <= x_c[i][l] - (y_c[i][l] >>> K);
					y_c[i+1][l] <= y_c[i][l] + (x_c[i][l] >>> K);
					z_c[i+1][l] <= z_c[i][l] - atan_q30(5'(K));
				end else begin
					x_c[i+1][l] <= x_c[i][l] + (y_c[i][l] >>> K);
					y_c[i+1][l] <= y_c[i][l] - (x_c[i][l] >>> K);
					z_c[i+1][l] <= z_c[i][l] + atan_q30(5'(K));
				end
			end
		end
	end

	// output stage: undo the half-turn fold
	logic                vld_o;
	logic [SIDE_W-1:0]   side_o;
	word_t               cos_o [2];
	word_t               sin_o [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else begin
			vld_o <= vld_c[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		side_o <= side_c[CORDIC_STAGES];
		for (int l = 0; l < 2; l++) begin
			if (flip_c[CORDIC_STAGES][l]) begin
				cos_o[l] <= 32'(-x_c[CORDIC_STAGES][l]);
				sin_o[l] <= 32'(-y_c[CORDIC_STAGES][l]);
			end else begin
				cos_o[l] <= 32'(x_c[CORDIC_STAGES][l]);
				sin_o[l] <= 32'(y_c[CORDIC_STAGES][l]);
			end
		end
	end

	assign out_valid = vld_o;
	assign out_side  = side_o;
	assign out_cos   = cos_o;
	assign out_sin   = sin_o;

endmodule

`default_nettype wire

// ----- sv/ptpi_arc_divide.sv -----
// ----------------------------------------------------------------------------
// ptpi_arc_divide: pipelined two-lane signed divider for the arc displacement
// Both numerators share the divisor w * 2^(30-FRAC_BITS); one quotient bit
// per stage, truncation toward zero, result clamped to +/- 2^32.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptpi_arc_divide #(
	parameter int FRAC_BITS = 16,
	parameter int SIDE_W    = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  ptpi_pkg::num_t      in_num [2],
	input  ptpi_pkg::word_t     in_rate,
	input  logic [SIDE_W-1:0]   in_side,
	output logic                out_valid,
	output ptpi_pkg::disp_t     out_quo [2],
	output logic [SIDE_W-1:0]   out_side
);
	import ptpi_pkg::*;

	localparam int S  = 30 - FRAC_BITS;
	localparam int QB = DISP_W;
	localparam int NB = 63;
	localparam int DB = 32 + S;
	localparam int RB = 33 + S;

	// entry stage: magnitudes, signs and overflow check
	logic [63:0]     an_full [2];
	logic [NB-1:0]   an [2];
	logic [31:0]     rmag;
	logic [DB-1:0]   den_abs;

	always_comb begin
		rmag    = in_rate[31] ? (32'd0 - 32'(in_rate)) : 32'(in_rate);
		den_abs = DB'(rmag) << S;
		for (int l = 0; l < 2; l++) begin
			an_full[l] = in_num[l][63] ? (64'd0 - 64'(in_num[l])) : 64'(in_num[l]);
			an[l]      = an_full[l][NB-1:0];
		end
	end

	logic            vld_s [QB+1];
	logic [SIDE_W-1:0] side_s [QB+1];
	logic [DB-1:0]   den_s [QB+1];
	logic [RB-1:0]   rem_s [QB+1][2];
	logic [QB-1:0]   low_s [QB+1][2];
	logic [QB-1:0]   quo_s [QB+1][2];
	logic            neg_s [QB+1][2];
	logic            ovf_s [QB+1][2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		side_s[0] <= in_side;
		den_s[0]  <= den_abs;
		for (int l = 0; l < 2; l++) begin
			rem_s[0][l] <= RB'(an[l][NB-1:QB]);
			low_s[0][l] <= an[l][QB-1:0];
			quo_s[0][l] <= '0;
			neg_s[0][l] <= in_num[l][63] ^ in_rate[31];
			ovf_s[0][l] <= RB'(an[l][NB-1:QB]) >= RB'(den_abs);
		end
	end

	// restoring steps, one quotient bit each
	for (genvar j = 0; j < QB; j++) begin : g_step
		logic [RB-1:0] sh [2];
		logic [RB:0]   tr [2];

		always_comb begin
			for (int l = 0; l < 2; l++) begin
				sh[l] = {rem_s[j][l][RB-2:0], low_s[j][l][QB-1]};
				tr[l] = {1'b0, sh[l]} - {1'b0, RB'(den_s[j])};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			side_s[j+1] <= side_s[j];
			den_s[j+1]  <= den_s[j];
			for (int l = 0; l < 2; l++) begin
				low_s[j+1][l] <= low_s[j][l] << 1;
				neg_s[j+1][l] <= neg_s[j][l];
				ovf_s[j+1][l] <= ovf_s[j][l];
				if (!tr[l][RB]) begin
					rem_s[j+1][l] <= tr[l][RB-1:0];
					quo_s[j+1][l] <= {quo_s[j][l][QB-2:0], 1'b1};
				end else begin
					rem_s[j+1][l] <= sh[l];
					quo_s[j+1][l] <= {quo_s[j][l][QB-2:0], 1'b0};
				end
			end
		end
	end

	// output stage: clamp and sign
	logic [QB-1:0]     qmag [2];
	logic              vld_o;
	logic [SIDE_W-1:0] side_o;
	disp_t             quo_o [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			qmag[l] = (ovf_s[QB][l] || quo_s[QB][l] > DISP_LIMIT) ? DISP_LIMIT : quo_s[QB][l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else begin
			vld_o <= vld_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		side_o <= side_s[QB];
		for (int l = 0; l < 2; l++) begin
			quo_o[l] <= neg_s[QB][l] ? -$signed(qmag[l]) : $signed(qmag[l]);
		end
	end

	assign out_valid = vld_o;
	assign out_side  = side_o;
	assign out_quo   = quo_o;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench of the planar twist pose integrator
// Drives pose and twist words with random gaps (none in the last random phase),
// predicts each new pose with an independent SE(2) integration model and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	import ptpi_pkg::*;

	localparam int FRAC    = 16;
	localparam int STAGES  = 18;
	localparam int LATENCY = STAGES + 48;

	localparam longint ONE30   = 64'sd1073741824;
	localparam longint TWOPI30 = 64'sd6746518852;
	localparam longint PI30    = 64'sd3373259426;
	localparam longint HPI30   = 64'sd1686629713;
	localparam longint GAIN30  = 64'sd652032874;
	localparam longint DLIM    = 64'sd4294967296;

	// angle table for the pose model, Q30
	localparam longint ATAN_TBL [0:31] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
		131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
		127, 63, 31, 15, 8, 4, 2, 1, 0};

	// pose prediction and in-order checking of new poses
	class pose_scoreboard;
		result_t pending_poses[$];
		longint  thresh;
		int      n_errors;
		int      n_checked;

		function automatic longint floor_shr(longint v, int s);
			return v >>> s;
		endfunction

		function automatic longint clip32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function automatic longint clip_disp(longint v);
			if (v > DLIM) return DLIM;
			if (v < -DLIM) return -DLIM;
			return v;
		endfunction

		function automatic bit is_small(longint v);
			longint m;
			m = (v < 0) ? -v : v;
			return m <= thresh;
		endfunction

		task automatic trig(input longint ang, output longint c, output longint s);
			longint r, x, y, z, nx;
			bit     flip;
			r = ang * (64'sd1 << (30 - FRAC));
			r = r % TWOPI30;
			flip = 0;
			if (r > PI30) r -= TWOPI30;
			else if (r < -PI30) r += TWOPI30;
			if (r > HPI30) begin
				r -= PI30;
				flip = 1;
			end else if (r < -HPI30) begin
				r += PI30;
				flip = 1;
			end
			x = GAIN30;
			y = 0;
			z = r;
			for (int i = 0; i < STAGES; i++) begin
				if (z >= 0) begin
					nx = x - floor_shr(y, i);
					y = y + floor_shr(x, i);
					z -= ATAN_TBL[i];
				end else begin
					nx = x + floor_shr(y, i);
					y = y - floor_shr(x, i);
					z += ATAN_TBL[i];
				end
				x = nx;
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		endtask

		// note an accepted word and queue its new pose
		task automatic note_item(input item_t it);
			longint th, px, py, w, vf, vl, dx, dy, dth, wc, ws, hc, hs, dv;
			longint nth, nx, ny;
			result_t r;
			th = it.pose_angle;
			px = it.pose_x;
			py = it.pose_y;
			w  = it.rate_angular;
			vf = it.rate_forward;
			vl = it.rate_lateral;
			if (!is_small(w)) begin
				trig(w, wc, ws);
				dv = w * (64'sd1 << (30 - FRAC));
				dx = clip_disp((vf * ws + vl * (wc - ONE30)) / dv);
				dy = clip_disp((vf * (ONE30 - wc) + vl * ws) / dv);
				dth = w;
			end else begin
				dx = vf;
				dy = vl;
				dth = 0;
			end
			trig(th, hc, hs);
			nx = clip32(px + floor_shr(hc * dx, 30) - floor_shr(hs * dy, 30));
			ny = clip32(py + floor_shr(hs * dx, 30) + floor_shr(hc * dy, 30));
			nth = clip32(th + dth);
			if (is_small(nth)) nth = 0;
			if (is_small(nx)) nx = 0;
			if (is_small(ny)) ny = 0;
			r.new_angle = nth[31:0];
			r.new_x = nx[31:0];
			r.new_y = ny[31:0];
			pending_poses.push_back(r);
		endtask

		// compare one result with the oldest expected pose
		task automatic check_result(input result_t got);
			result_t e;
			if (pending_poses.size() == 0) begin
				$display("%0t unexpected result %h", $time, got);
				n_errors++;
				return;
			end
			e = pending_poses.pop_front();
			n_checked++;
			if (got.new_angle !== e.new_angle) begin
				$display("%0t new_angle exp %h got %h", $time, e.new_angle, got.new_angle);
				n_errors++;
			end
			if (got.new_x !== e.new_x) begin
				$display("%0t new_x exp %h got %h", $time, e.new_x, got.new_x);
				n_errors++;
			end
			if (got.new_y !== e.new_y) begin
				$display("%0t new_y exp %h got %h", $time, e.new_y, got.new_y);
				n_errors++;
			end
		endtask
	endclass

	logic    clk = 0;
	logic    arst_n = 0;
	logic    start = 0;
	logic    busy;
	item_t   item = '0;
	logic    cfg_we = 0;
	thresh_t cfg_wdata = '0;
	logic    done;
	result_t result;

	pose_scoreboard sb;
	bit             no_gaps;
	int             n_sent;

	planar_twist_pose_integrator #(
		.FRAC_BITS    (FRAC),
		.CORDIC_STAGES(STAGES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.done     (done),
		.result   (result)
	);

	// clock
	always #5 clk = ~clk;

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) sb.check_result(result);
	end

	function automatic word_t rand_word(int mode);
		case (mode)
			0: return $urandom();
			1: return $signed(32'($urandom_range(0, 20000))) - 10000;
			2: return $signed(32'($urandom_range(0, 800000))) - 400000;
			default: return $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 3)
				: 32'sh80000000 + $urandom_range(0, 3);
		endcase
	endfunction

	// send one word, held until accepted
	task automatic send_word(input item_t it);
		int gap;
		if (!no_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		sb.note_item(it);
		n_sent++;
	endtask

	// wait until every expected pose has come out, then drain the pipe
	task automatic drain_pipe();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending_poses.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_thresh(input thresh_t v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.thresh = v;
	endtask

	function automatic item_t rand_item();
		item_t it;
		it.pose_angle   = rand_word($urandom_range(0, 3));
		it.pose_x       = rand_word($urandom_range(0, 3));
		it.pose_y       = rand_word($urandom_range(0, 3));
		it.rate_angular = rand_word($urandom_range(0, 3));
		it.rate_forward = rand_word($urandom_range(0, 3));
		it.rate_lateral = rand_word($urandom_range(0, 3));
		if ($urandom_range(0, 9) == 0) it.rate_angular = $urandom_range(0, 1) ? 0 : 1;
		if ($urandom_range(0, 9) == 0) begin
			it.rate_forward = 0;
			it.rate_lateral = 0;
		end
		return it;
	endfunction

	// stimulus
	initial begin
		item_t   it;
		thresh_t th_list [0:4];
		sb = new();
		sb.thresh = 0;
		th_list = '{16'd0, 16'd65535, 16'd3, 16'd300, 16'd0};
		no_gaps = 0;
		n_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words at reset threshold
		it = '0;
		send_word(it);
		it = '{32'sd65536, 32'sd100, -32'sd100, 32'sd0, 32'sd0, 32'sd0};
		send_word(it);
		it = '{32'sd0, 32'sd0, 32'sd0, 32'sd102944, 32'sd65536, 32'sd0};
		send_word(it);
		it = '{32'sd205887, 32'sd0, 32'sd0, -32'sd205887, 32'sd65536, -32'sd65536};
		send_word(it);
		it = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 32'sh7fffffff};
		send_word(it);
		it = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh80000000};
		send_word(it);
		it = '{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sd1,
			32'sh7fffffff, 32'sh80000000};
		send_word(it);
		it = '{-32'sd65536, -32'sd2, 32'sd2, 32'sd0, 32'sd1, -32'sd1};
		send_word(it);
		it = '{32'sd1, 32'sd0, 32'sd0, -32'sd1, 32'sh40000000, 32'sh40000000};
		send_word(it);
		drain_pipe();

		// threshold snapping and near-zero angular rate
		write_thresh(16'd200);
		it = '{32'sd150, 32'sd199, -32'sd201, 32'sd200, 32'sd0, 32'sd0};
		send_word(it);
		it = '{32'sd0, 32'sd0, 32'sd0, -32'sd200, 32'sd500, 32'sd100};
		send_word(it);
		it = '{32'sd0, 32'sd0, 32'sd0, 32'sd201, 32'sd65536, 32'sd65536};
		send_word(it);
		it = '{-32'sd100, 32'sd0, 32'sd0, 32'sd150, 32'sd0, 32'sd0};
		send_word(it);
		drain_pipe();

		// random phases across threshold settings
		for (int ph = 0; ph < 5; ph++) begin
			write_thresh(th_list[ph]);
			if (ph == 4) no_gaps = 1;
			for (int n = 0; n < 366; n++) send_word(rand_item());
			drain_pipe();
		end

		$display("sent %0d pose words over 7 threshold settings, checked %0d results",
			n_sent, sb.n_checked);
		if (sb.n_errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// run limit
	initial begin
		#5000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
sv/ptpi_pkg.sv
sv/ptpi_sincos.sv
sv/ptpi_arc_divide.sv
sv/planar_twist_pose_integrator.sv
tb/tb_top.sv
